/* hdl/grid_line_of_sight_defines.svh */
// -----------------------------------------------------------------------------
// Grid line of sight: assertion macros
// Shared concurrent assertion forms used by the RTL of the block.
// -----------------------------------------------------------------------------
`ifndef GRID_LINE_OF_SIGHT_DEFINES_SVH
`define GRID_LINE_OF_SIGHT_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define GLOS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grid_line_of_sight: same-cycle check failed");

// Next-cycle implication, switched off while reset is held.
`define GLOS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grid_line_of_sight: next-cycle check failed");

`endif

/* hdl/glos_pkg.sv */
// -----------------------------------------------------------------------------
// Grid line of sight: package
// Types and fixed constants shared by the block's modules.
// -----------------------------------------------------------------------------
package glos_pkg;

    localparam int COORD_W = 6;
    localparam int CFG_W   = 7;
    localparam int ERR_W   = 9;

    localparam logic [CFG_W-1:0] GRID_SIZE_RESET = 7'd64;

    // Configuration register indexes
    localparam logic [0:0] CFG_GRID_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_GRID_HEIGHT = 1'b1;

    // Input mode codes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic start;
        logic step;
    } t_walk_ctl;

    typedef struct packed {
        logic at_source;
        logic at_target;
    } t_walk_stat;

endpackage

/* hdl/glos_walker.sv */
// -----------------------------------------------------------------------------
// Grid line of sight: line walker
// Holds the Bresenham state of one query and advances it one cell per step.
// -----------------------------------------------------------------------------
module glos_walker (
    input  logic                           i_clk,
    input  glos_pkg::t_walk_ctl            i_ctl,
    input  logic [glos_pkg::COORD_W-1:0]   i_from_x,
    input  logic [glos_pkg::COORD_W-1:0]   i_from_y,
    input  logic [glos_pkg::COORD_W-1:0]   i_to_x,
    input  logic [glos_pkg::COORD_W-1:0]   i_to_y,
    output logic [glos_pkg::COORD_W-1:0]   o_cur_x,
    output logic [glos_pkg::COORD_W-1:0]   o_cur_y,
    output glos_pkg::t_walk_stat           o_stat
);

    logic [glos_pkg::COORD_W-1:0]       r_cx, r_cy, r_tx, r_ty, r_dx, r_dy;
    logic                               r_stx_pos, r_sty_pos, r_at_src;
    logic signed [glos_pkg::ERR_W-1:0]  r_err;

    logic [glos_pkg::COORD_W-1:0]       n_dx, n_dy;
    logic signed [glos_pkg::ERR_W:0]    twice, dx_s, dy_s;
    logic                               move_x, move_y;
    logic signed [glos_pkg::ERR_W-1:0]  n_err;

    always_comb begin
        n_dx = (i_from_x > i_to_x) ? (i_from_x - i_to_x) : (i_to_x - i_from_x);
        n_dy = (i_from_y > i_to_y) ? (i_from_y - i_to_y) : (i_to_y - i_from_y);
    end

    always_comb begin
        twice  = {r_err, 1'b0};
        dx_s   = $signed({{(glos_pkg::ERR_W + 1 - glos_pkg::COORD_W){1'b0}}, r_dx});
        dy_s   = $signed({{(glos_pkg::ERR_W + 1 - glos_pkg::COORD_W){1'b0}}, r_dy});
        move_x = twice > -dy_s;
        move_y = twice < dx_s;
        n_err  = r_err
               - (move_x ? dy_s[glos_pkg::ERR_W-1:0] : '0)
               + (move_y ? dx_s[glos_pkg::ERR_W-1:0] : '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_cx      <= i_from_x;
            r_cy      <= i_from_y;
            r_tx      <= i_to_x;
            r_ty      <= i_to_y;
            r_dx      <= n_dx;
            r_dy      <= n_dy;
            r_stx_pos <= i_from_x < i_to_x;
            r_sty_pos <= i_from_y < i_to_y;
            r_err     <= $signed({{(glos_pkg::ERR_W - glos_pkg::COORD_W){1'b0}}, n_dx})
                       - $signed({{(glos_pkg::ERR_W - glos_pkg::COORD_W){1'b0}}, n_dy});
            r_at_src  <= 1'b1;
        end else if (i_ctl.step) begin
            // Away from the target at least one axis always moves, so the
            // walk never comes back to the source cell.
            if (move_x) begin
                r_cx <= r_stx_pos ? r_cx + 1'b1 : r_cx - 1'b1;
            end
            if (move_y) begin
                r_cy <= r_sty_pos ? r_cy + 1'b1 : r_cy - 1'b1;
            end
            r_err    <= n_err;
            r_at_src <= 1'b0;
        end
    end

    assign o_cur_x          = r_cx;
    assign o_cur_y          = r_cy;
    assign o_stat.at_source = r_at_src;
    assign o_stat.at_target = (r_cx == r_tx) && (r_cy == r_ty);

endmodule

/* hdl/grid_line_of_sight.sv */
// -----------------------------------------------------------------------------
// Grid line of sight: top level
// Wall bitmap with Bresenham line-of-sight queries.
// -----------------------------------------------------------------------------
// The wall bitmap lives in one single-bit memory of GRID_WIDTH_MAX *
// GRID_HEIGHT_MAX entries. After reset a clearing pass writes every entry to
// zero, one per cycle. No item is taken during that time, though
// configuration writes are. A query walks the line one cell per cycle,
// reading the memory for each cell. The walk covers the number of steps from
// source to target (the longer of the two axis distances, at most 63) before
// its result is loaded into the output register. A wall met on the way ends
// the walk sooner, and a result still stalled in the output register holds
// the query in its final state. The next item may be accepted while that
// result waits to be taken.
`include "grid_line_of_sight_defines.svh"

module grid_line_of_sight #(
    parameter int GRID_WIDTH_MAX  = 64,
    parameter int GRID_HEIGHT_MAX = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [0:0]                     i_cfg_index,
    input  logic [glos_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_mode,
    input  logic [glos_pkg::COORD_W-1:0]   i_write_x,
    input  logic [glos_pkg::COORD_W-1:0]   i_write_y,
    input  logic                           i_wall_bit,
    input  logic [glos_pkg::COORD_W-1:0]   i_from_x,
    input  logic [glos_pkg::COORD_W-1:0]   i_from_y,
    input  logic [glos_pkg::COORD_W-1:0]   i_to_x,
    input  logic [glos_pkg::COORD_W-1:0]   i_to_y,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_sight_clear
);

    localparam int DEPTH  = GRID_WIDTH_MAX * GRID_HEIGHT_MAX;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    glos_pkg::t_state     r_state, n_state;
    logic [ADDR_W-1:0]    r_clr_addr;
    logic                 r_pend, n_pend;
    logic                 r_res;
    logic                 r_out_valid, r_out_clear;
    logic [glos_pkg::CFG_W-1:0] r_grid_width, r_grid_height;

    logic                 r_wall_mem [DEPTH];
    logic                 r_rd_bit;

    glos_pkg::t_walk_ctl  walk_ctl;
    glos_pkg::t_walk_stat walk_stat;
    logic [glos_pkg::COORD_W-1:0] cur_x, cur_y;

    logic                 in_accept, wr_in_range, hit, in_grid, out_free;
    logic                 query_acc, write_acc, out_load, walking;
    logic                 mem_we, mem_wdata;
    logic [ADDR_W-1:0]    mem_waddr, rd_addr;

    glos_walker u_walker (
        .i_clk    (i_clk),
        .i_ctl    (walk_ctl),
        .i_from_x (i_from_x),
        .i_from_y (i_from_y),
        .i_to_x   (i_to_x),
        .i_to_y   (i_to_y),
        .o_cur_x  (cur_x),
        .o_cur_y  (cur_y),
        .o_stat   (walk_stat)
    );

    assign in_accept   = i_valid && !o_stall;
    assign query_acc   = in_accept && i_mode == glos_pkg::MODE_QUERY;
    assign write_acc   = in_accept && i_mode == glos_pkg::MODE_WRITE;
    assign walking     = r_state == glos_pkg::ST_WALK;
    assign wr_in_range = (int'(i_write_x) < GRID_WIDTH_MAX)
                      && (int'(i_write_y) < GRID_HEIGHT_MAX);
    assign hit         = r_pend && r_rd_bit;
    assign out_free    = !r_out_valid || !i_stall;
    assign out_load    = r_state == glos_pkg::ST_DONE && out_free;

    // A cell blocks only inside both the configured grid and the storage.
    assign in_grid = ({1'b0, cur_x} < r_grid_width) && (int'(cur_x) < GRID_WIDTH_MAX)
                  && ({1'b0, cur_y} < r_grid_height) && (int'(cur_y) < GRID_HEIGHT_MAX);
    assign rd_addr = ADDR_W'(int'(cur_y) * GRID_WIDTH_MAX + int'(cur_x));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            glos_pkg::ST_CLEAR: begin
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = glos_pkg::ST_IDLE;
                end
            end
            glos_pkg::ST_IDLE: begin
                if (query_acc) begin
                    n_state = glos_pkg::ST_WALK;
                end
            end
            glos_pkg::ST_WALK: begin
                if (hit || walk_stat.at_target) begin
                    n_state = glos_pkg::ST_DONE;
                end
            end
            glos_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = glos_pkg::ST_IDLE;
                end
            end
            default: n_state = glos_pkg::ST_CLEAR;
        endcase
    end

    // Outputs of the state machine
    always_comb begin
        o_stall        = 1'b1;
        walk_ctl.start = 1'b0;
        walk_ctl.step  = 1'b0;
        n_pend         = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = rd_addr;
        mem_wdata      = 1'b0;
        unique case (r_state)
            glos_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
            end
            glos_pkg::ST_IDLE: begin
                o_stall        = 1'b0;
                walk_ctl.start = query_acc;
                mem_we         = write_acc && wr_in_range;
                mem_waddr      = ADDR_W'(int'(i_write_y) * GRID_WIDTH_MAX + int'(i_write_x));
                mem_wdata      = i_wall_bit;
            end
            glos_pkg::ST_WALK: begin
                // The read issued now is checked in the next cycle.
                walk_ctl.step = !hit && !walk_stat.at_target;
                n_pend        = walk_ctl.step && !walk_stat.at_source && in_grid;
            end
            glos_pkg::ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_wall_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_bit <= r_wall_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (walking) begin
            r_res <= !hit;
        end
        if (out_load) begin
            r_out_clear <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= glos_pkg::ST_CLEAR;
            r_clr_addr    <= '0;
            r_pend        <= 1'b0;
            r_out_valid   <= 1'b0;
            r_grid_width  <= glos_pkg::GRID_SIZE_RESET;
            r_grid_height <= glos_pkg::GRID_SIZE_RESET;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            if (r_state == glos_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    glos_pkg::CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_data;
                    glos_pkg::CFG_GRID_HEIGHT: r_grid_height <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_sight_clear = r_out_clear;

    `GLOS_ASSERT_NEXT(a_query_starts_walk, i_clk, i_rst_n, query_acc, walking)
    `GLOS_ASSERT_NEXT(a_write_stays_idle, i_clk, i_rst_n, write_acc, r_state == glos_pkg::ST_IDLE)
    `GLOS_ASSERT_IMPL(a_pend_only_walking, i_clk, i_rst_n, r_pend, walking)
    `GLOS_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, out_load, r_out_valid && r_out_clear == $past(r_res))
    `GLOS_ASSERT_IMPL(a_no_read_at_source, i_clk, i_rst_n, walking && walk_stat.at_source, !n_pend)

endmodule
